>>> hw/rtl/pbm_pkg.sv
package pbm_pkg;

   localparam int ROM_OFFSET_BITS = 20;
   localparam int RAM_OFFSET_BITS = 16;
   localparam int OFFSET_W        = 20;

   localparam logic [OFFSET_W-1:0] ROM_MASK = OFFSET_W'((64'd1 << ROM_OFFSET_BITS) - 64'd1);
   localparam logic [OFFSET_W-1:0] RAM_MASK = OFFSET_W'((64'd1 << RAM_OFFSET_BITS) - 64'd1);

   localparam logic [15:0] ADDR_MODE     = 16'h5100;
   localparam logic [15:0] ADDR_PROT0    = 16'h5102;
   localparam logic [15:0] ADDR_PROT1    = 16'h5103;
   localparam logic [15:0] ADDR_RAM_BANK = 16'h5113;
   localparam logic [15:0] ADDR_BANK_LO  = 16'h5114;
   localparam logic [15:0] ADDR_MUL_LO   = 16'h5205;
   localparam logic [15:0] ADDR_MUL_HI   = 16'h5206;

   localparam logic [2:0] WINDOW_RAM_PAGE = 3'b011;  // $6000-$7FFF

   localparam logic [1:0] PROT_KEY0 = 2'd2;
   localparam logic [1:0] PROT_KEY1 = 2'd1;

   localparam logic [7:0] BANK_COUNT_RST = 8'd32;
   localparam logic [7:0] LAST_BANK_RST  = BANK_COUNT_RST - 8'd1;
   localparam logic [1:0] MODE_RST       = 2'd3;

   localparam int DIV_STEPS = 4;  // two quotient bits per step over an 8-bit dividend
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [2:0] {
      TGT_NONE = 3'd0,
      TGT_ROM  = 3'd1,
      TGT_RAMR = 3'd2,
      TGT_RAMW = 3'd3,
      TGT_REG  = 3'd4
   } pbm_target_type;

   typedef enum logic [1:0] {
      MODE_32K    = 2'd0,
      MODE_16K    = 2'd1,
      MODE_16K_8K = 2'd2,
      MODE_8K     = 2'd3
   } pbm_mode_type;

   typedef enum logic [1:0] {
      SZ_8K  = 2'd0,
      SZ_16K = 2'd1,
      SZ_32K = 2'd2
   } pbm_size_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_FINISH
   } pbm_state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic div_step;
      logic finish;
   } pbm_cmd_type;

   typedef struct packed {
      logic need_div;
   } pbm_status_type;

endpackage

>>> hw/rtl/pbm_req_if.sv
interface pbm_req_if import pbm_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] address;
   logic [7:0]  wdata;

   modport source (output valid, output opcode, output address, output wdata, input ready);
   modport sink (input valid, input opcode, input address, input wdata, output ready);
endinterface

>>> hw/rtl/pbm_rsp_if.sv
interface pbm_rsp_if import pbm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [2:0]          target;
   logic [OFFSET_W-1:0] offset;
   logic [7:0]          rdata;

   modport source (output valid, output target, output offset, output rdata, input ready);
   modport sink (input valid, input target, input offset, input rdata, output ready);
endinterface

>>> hw/rtl/pbm_csr_if.sv
interface pbm_csr_if import pbm_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/pbm_ctrl.sv
module pbm_ctrl import pbm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  pbm_status_type status,
   output pbm_cmd_type    cmd
);

   pbm_state_type        state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            cnt_in   = '0;
            state_in = status.need_div ? ST_DIVIDE : ST_FINISH;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold the result until the output register is free
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EVAL))
      else $error("accepted request did not enter evaluation");

   a_divide_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) |=> (state_ff == ST_FINISH))
      else $error("divider did not finish after its step count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a pending response");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");

endmodule

>>> hw/rtl/pbm_datapath.sv
module pbm_datapath import pbm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  pbm_cmd_type         cmd,
   output pbm_status_type      status,
   input  logic                req_opcode,
   input  logic [15:0]         req_address,
   input  logic [7:0]          req_wdata,
   input  logic                csr_write,
   input  logic [7:0]          csr_data,
   output logic [2:0]          rsp_target,
   output logic [OFFSET_W-1:0] rsp_offset,
   output logic [7:0]          rsp_rdata
);

   // captured request
   logic        op_ff;
   logic [15:0] addr_ff;
   logic [7:0]  wdata_ff;

   // mapper state
   logic [7:0]   bank_count_ff;
   pbm_mode_type bank_mode_ff, pending_mode_ff;
   logic         mode_armed_ff;
   logic [3:0]   last_region_ff;
   logic [2:0]   ram_bank_ff;
   logic [7:0]   bank_regs_ff [4];
   logic [1:0]   protect_ff [2];
   logic [7:0]   mul_ff [2];

   // staged result
   pbm_target_type      res_tgt_ff, res_tgt_in;
   logic [OFFSET_W-1:0] res_off_ff, res_off_in;
   logic [7:0]          res_dat_ff, res_dat_in;
   logic                need_div_ff;
   pbm_size_type        size_ff, size_in;
   logic [14:0]         loc_ff, loc_in;

   // remainder unit
   logic [7:0] dvd_ff, dvd_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] dsr_ff, dsr_in;
   logic [8:0] part1, part2;

   // output register
   pbm_target_type      out_tgt_ff;
   logic [OFFSET_W-1:0] out_off_ff;
   logic [7:0]          out_dat_ff;

   logic         is_write, is_read, in_ram_page, in_prg;
   logic [3:0]   region;
   logic         mode_switch;
   pbm_mode_type eff_mode;
   logic [7:0]   sel_reg;
   logic         force_rom;
   logic         need_div;
   logic [15:0]  product;
   logic [OFFSET_W-1:0] ram_win_off;
   logic [OFFSET_W-1:0] prg_ram_off;
   logic [6:0]   bank_idx;
   logic [7:0]   rom_bank;
   logic [21:0]  rom_full;

   assign is_write    = (op_ff == OP_WRITE);
   assign is_read     = (op_ff == OP_READ);
   assign in_ram_page = (addr_ff[15:13] == WINDOW_RAM_PAGE);
   assign in_prg      = addr_ff[15];
   assign region      = addr_ff[15:12];
   assign mode_switch = is_read && in_prg && mode_armed_ff && (last_region_ff != region);
   assign eff_mode    = mode_switch ? pending_mode_ff : bank_mode_ff;
   assign product     = 16'(mul_ff[0]) * 16'(mul_ff[1]);
   assign ram_win_off = ((OFFSET_W'(ram_bank_ff) << 13) + OFFSET_W'(addr_ff[12:0])) & RAM_MASK;
   assign status.need_div = need_div;

   // pick the bank register and window size for a PRG read
   always_comb begin
      sel_reg   = bank_regs_ff[3];
      size_in   = SZ_8K;
      force_rom = 1'b0;
      case (eff_mode)
         MODE_32K: begin
            size_in   = SZ_32K;
            force_rom = 1'b1;
         end
         MODE_16K: begin
            size_in   = SZ_16K;
            sel_reg   = addr_ff[14] ? bank_regs_ff[3] : bank_regs_ff[1];
            force_rom = addr_ff[14];
         end
         MODE_16K_8K: begin
            if (!addr_ff[14]) begin
               size_in = SZ_16K;
               sel_reg = bank_regs_ff[1];
            end else begin
               sel_reg   = addr_ff[13] ? bank_regs_ff[3] : bank_regs_ff[2];
               force_rom = addr_ff[13];
            end
         end
         MODE_8K: begin
            sel_reg   = bank_regs_ff[addr_ff[14:13]];
            force_rom = (addr_ff[14:13] == 2'd3);
         end
         default: begin
            force_rom = 1'b1;
         end
      endcase
      case (size_in)
         SZ_8K:   loc_in = {2'b00, addr_ff[12:0]};
         SZ_16K:  loc_in = {1'b0, addr_ff[13:0]};
         default: loc_in = addr_ff[14:0];
      endcase
   end

   assign prg_ram_off = ((OFFSET_W'(sel_reg[2:0]) << (5'd13 + 5'(size_in)))
                         + OFFSET_W'(loc_in)) & RAM_MASK;

   // decode the access into a staged result
   always_comb begin
      res_tgt_in = TGT_NONE;
      res_off_in = '0;
      res_dat_in = '0;
      need_div   = 1'b0;
      bank_idx   = '0;
      dsr_in     = bank_count_ff;
      case (size_in)
         SZ_8K:   bank_idx = sel_reg[6:0];
         SZ_16K:  bank_idx = {1'b0, sel_reg[6:1]};
         default: bank_idx = {2'b00, sel_reg[6:2]};
      endcase
      case (size_in)
         SZ_8K:   dsr_in = bank_count_ff;
         SZ_16K:  dsr_in = {1'b0, bank_count_ff[7:1]};
         default: dsr_in = {2'b00, bank_count_ff[7:2]};
      endcase
      if (is_write) begin
         if (in_ram_page && protect_ff[0] == PROT_KEY0 && protect_ff[1] == PROT_KEY1) begin
            res_tgt_in = TGT_RAMW;
            res_off_in = ram_win_off;
            res_dat_in = wdata_ff;
         end
      end else if (addr_ff == ADDR_MUL_LO || addr_ff == ADDR_MUL_HI) begin
         res_tgt_in = TGT_REG;
         res_dat_in = (addr_ff == ADDR_MUL_LO) ? product[7:0] : product[15:8];
      end else if (in_ram_page) begin
         res_tgt_in = TGT_RAMR;
         res_off_in = ram_win_off;
      end else if (in_prg) begin
         if (force_rom || sel_reg[7]) begin
            res_tgt_in = TGT_ROM;
            need_div   = 1'b1;
         end else begin
            res_tgt_in = TGT_RAMR;
            res_off_in = prg_ram_off;
         end
      end
   end

   // two restoring steps per cycle; remainder stays below a nonzero divisor
   always_comb begin
      part1 = {rem_ff, dvd_ff[7]};
      if (part1 >= {1'b0, dsr_ff}) begin
         part1 = part1 - {1'b0, dsr_ff};
      end
      part2 = {part1[7:0], dvd_ff[6]};
      if (part2 >= {1'b0, dsr_ff}) begin
         part2 = part2 - {1'b0, dsr_ff};
      end
      rem_in = part2[7:0];
      dvd_in = {dvd_ff[5:0], 2'b00};
   end

   assign rom_bank = (dsr_ff == 8'd0) ? 8'd0 : rem_ff;
   assign rom_full = (22'(rom_bank) << (5'd13 + 5'(size_ff))) + 22'(loc_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         addr_ff  <= req_address;
         wdata_ff <= req_wdata;
      end
      if (cmd.eval) begin
         res_tgt_ff  <= res_tgt_in;
         res_off_ff  <= res_off_in;
         res_dat_ff  <= res_dat_in;
         need_div_ff <= need_div;
         size_ff     <= size_in;
         loc_ff      <= loc_in;
         dvd_ff      <= {1'b0, bank_idx};
         dsr_ff      <= dsr_in;
         rem_ff      <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
      if (cmd.finish) begin
         out_tgt_ff <= res_tgt_ff;
         out_dat_ff <= res_dat_ff;
         out_off_ff <= need_div_ff ? (rom_full[OFFSET_W-1:0] & ROM_MASK) : res_off_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_count_ff   <= BANK_COUNT_RST;
         bank_mode_ff    <= pbm_mode_type'(MODE_RST);
         pending_mode_ff <= pbm_mode_type'(MODE_RST);
         mode_armed_ff   <= 1'b0;
         last_region_ff  <= '0;
         ram_bank_ff     <= '0;
         bank_regs_ff[0] <= '0;
         bank_regs_ff[1] <= '0;
         bank_regs_ff[2] <= '0;
         bank_regs_ff[3] <= LAST_BANK_RST;
         protect_ff[0]   <= '0;
         protect_ff[1]   <= '0;
         mul_ff[0]       <= '0;
         mul_ff[1]       <= '0;
      end else begin
         if (csr_write) begin
            bank_count_ff <= csr_data;
         end
         if (cmd.eval && is_write) begin
            if (addr_ff == ADDR_MODE) begin
               pending_mode_ff <= pbm_mode_type'(wdata_ff[1:0]);
            end else if (addr_ff == ADDR_PROT0 || addr_ff == ADDR_PROT1) begin
               protect_ff[addr_ff[0]] <= wdata_ff[1:0];
            end else if (addr_ff == ADDR_RAM_BANK) begin
               ram_bank_ff <= wdata_ff[2:0];
            end else if (addr_ff[15:2] == ADDR_BANK_LO[15:2]) begin
               bank_regs_ff[addr_ff[1:0]] <= wdata_ff;
               mode_armed_ff              <= 1'b1;
            end else if (addr_ff == ADDR_MUL_LO || addr_ff == ADDR_MUL_HI) begin
               mul_ff[~addr_ff[0]] <= wdata_ff;
            end
         end
         if (cmd.eval && is_read && in_prg) begin
            last_region_ff <= region;
            if (mode_switch) begin
               bank_mode_ff  <= pending_mode_ff;
               mode_armed_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_target = out_tgt_ff;
   assign rsp_offset = out_off_ff;
   assign rsp_rdata  = out_dat_ff;

   a_switch_disarms: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && mode_switch) |=> (!mode_armed_ff && bank_mode_ff == $past(pending_mode_ff)))
      else $error("mode switch did not take the pending mode");

   a_prg_read_region: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && is_read && in_prg) |=> (last_region_ff == $past(region)))
      else $error("PRG read did not record its region");

   a_rom_needs_div: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> (need_div == (res_tgt_in == TGT_ROM)))
      else $error("ROM mapping without bank reduction");

endmodule

>>> hw/rtl/prg_bank_mapper_unit.sv
// PRG bank mapper: one CPU bus access per request on req_port (opcode, address, wdata),
// one response per request on rsp_port (target, offset, rdata), both valid/ready.
// csr_port writes the 8K ROM bank count; it is ready whenever reset is low. The user
// must write it only while no request is in flight; the block does not enforce this.
// Register writes at $5100-$5206 update the mapper state and answer with target none.
// Reads of $8000-$FFFF map through the bank registers to a ROM or RAM offset.
// An accepted request is evaluated and then finished into the output register;
// ROM-mapped reads also pass through the bank remainder unit between the two,
// which retires two quotient bits a cycle against the bank count.
// One request is processed at a time.
// A new request is accepted while a finished response still waits in the output
// register; when the receiver stalls, the following result is held internally and
// no further request is taken until the response moves.
// Synchronous reset restores the bank count to 32, mode 3, and the last bank
// register to bank 31; no channel accepts during reset and no response is pending.
module prg_bank_mapper_unit import pbm_pkg::*; (
   input logic       clock,
   input logic       reset,
   pbm_req_if.sink   req_port,
   pbm_rsp_if.source rsp_port,
   pbm_csr_if.sink   csr_port
);

   pbm_cmd_type    cmd;
   pbm_status_type status;
   logic           csr_write;

   assign csr_port.ready = !reset;
   assign csr_write      = csr_port.valid && csr_port.ready;

   pbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pbm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_opcode  (req_port.opcode),
      .req_address (req_port.address),
      .req_wdata   (req_port.wdata),
      .csr_write   (csr_write),
      .csr_data    (csr_port.data),
      .rsp_target  (rsp_port.target),
      .rsp_offset  (rsp_port.offset),
      .rsp_rdata   (rsp_port.rdata)
   );

endmodule
